// ----- rtl/core/listmode_buffer_deframer_assert.svh -----
// Assertion macros used by the list-mode deframer word parser.
`ifndef LISTMODE_BUFFER_DEFRAMER_ASSERT_SVH
`define LISTMODE_BUFFER_DEFRAMER_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define LMBD_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define LMBD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/lmbd_pkg.sv -----
// Types and constants of the list-mode buffer deframer.
package lmbd_pkg;

   // Result kinds
   localparam logic [1:0] KIND_EVENT  = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;
   localparam logic [1:0] KIND_END    = 2'd3;

   // Error codes
   localparam logic ERR_STREAM_SIG = 1'b0;
   localparam logic ERR_BUFFER_SIG = 1'b1;

   // Four-word signatures, first word in the top bits
   localparam logic [63:0] SIG_STREAM = 64'h0000_5555_AAAA_FFFF;
   localparam logic [63:0] SIG_BUFFER = 64'h0000_FFFF_5555_AAAA;
   localparam logic [63:0] SIG_END    = 64'hFFFF_AAAA_5555_0000;

   // Divide by three: (x * 0xAAAB) >> 17 is exact for 16-bit x
   localparam logic [15:0] DIV3_MAGIC = 16'hAAAB;

   // Widths
   localparam int WORD_W  = 16;
   localparam int WC_W    = 5;
   localparam int RAW48_W = 48;
   localparam int TIME_W  = 55;

   // Queue between the parser and the output stage
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // One queued result item; hdr_fields is buffer number:run id:word 5
   typedef struct packed {
      logic [1:0]         kind;
      logic [RAW48_W-1:0] event_data;
      logic [RAW48_W-1:0] time_raw;
      logic [RAW48_W-1:0] hdr_fields;
      logic               error_code;
   } entry_type;

   // Queue status seen by the parser and the output stage
   typedef struct packed {
      logic full;
      logic valid;
   } qstat_type;

   // Scale a raw timestamp by 100: 64x + 32x + 4x
   function automatic logic [TIME_W-1:0] scale_ns(input logic [RAW48_W-1:0] raw);
      logic [TIME_W-1:0] ext;
      ext = TIME_W'(raw);
      return (ext << 6) + (ext << 5) + (ext << 2);
   endfunction

endpackage

// ----- rtl/core/lmbd_front.sv -----
// Word parser: signature checks, header capture and event assembly.
`include "listmode_buffer_deframer_assert.svh"

module lmbd_front #(
   parameter int HEADER_WORDS = 21
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [15:0]                req_data_word,
   input  lmbd_pkg::qstat_type        qstat,
   output logic                       push,
   output lmbd_pkg::entry_type        push_entry
);

   localparam logic [2:0] PH_STREAM_SIG = 3'd0;
   localparam logic [2:0] PH_HEADER     = 3'd1;
   localparam logic [2:0] PH_EVENTS     = 3'd2;
   localparam logic [2:0] PH_BUF_SIG    = 3'd3;
   localparam logic [2:0] PH_LOOKAHEAD  = 3'd4;
   localparam logic [2:0] PH_DONE       = 3'd5;
   localparam logic [2:0] PH_HALTED     = 3'd6;

   localparam logic [lmbd_pkg::WC_W-1:0] LAST_WORD = lmbd_pkg::WC_W'(HEADER_WORDS - 1);

   logic [2:0]                   phase_ff, phase_in;
   logic [lmbd_pkg::WC_W-1:0]    wc_ff, wc_in;
   logic [15:0]                  events_left_ff, events_left_in;
   logic [15:0]                  la_ff [3];
   logic [15:0]                  la_in [3];
   logic [15:0]                  blen_ff, blen_in;
   logic [15:0]                  hlen_ff, hlen_in;
   logic [15:0]                  diff_ff, diff_in;
   logic [15:0]                  quot_ff, quot_in;
   logic [31:0]                  prod;
   logic [47:0]                  ts_ff, ts_in;
   logic [47:0]                  hdr_ff, hdr_in;
   logic [31:0]                  partial_ff, partial_in;
   logic [63:0]                  la_word;
   logic                         take;

   // Stall only when the queue has no room
   assign req_stall = qstat.full;
   assign take      = req_valid & ~qstat.full;
   assign la_word   = {la_ff[0], la_ff[1], la_ff[2], req_data_word};

   // Event count: clamp the length difference, then divide by three
   assign diff_in = (blen_ff >= hlen_ff) ? (blen_ff - hlen_ff) : 16'd0;
   assign prod    = 32'(diff_ff) * 32'(lmbd_pkg::DIV3_MAGIC);
   assign quot_in = {1'b0, prod[31:17]};

   // Advance the parser on each accepted word
   always_comb begin
      phase_in       = phase_ff;
      wc_in          = wc_ff;
      events_left_in = events_left_ff;
      la_in          = la_ff;
      blen_in        = blen_ff;
      hlen_in        = hlen_ff;
      ts_in          = ts_ff;
      hdr_in         = hdr_ff;
      partial_in     = partial_ff;
      push           = 1'b0;
      push_entry     = '0;
      if (take) begin
         case (phase_ff)
            PH_STREAM_SIG, PH_BUF_SIG, PH_LOOKAHEAD: begin
               if (wc_ff[1:0] != 2'd3) begin
                  case (wc_ff[1:0])
                     2'd0: la_in[0] = req_data_word;
                     2'd1: la_in[1] = req_data_word;
                     default: la_in[2] = req_data_word;
                  endcase
                  wc_in = wc_ff + 5'd1;
               end else begin
                  wc_in = '0;
                  if (phase_ff == PH_STREAM_SIG) begin
                     if (la_word == lmbd_pkg::SIG_STREAM) begin
                        phase_in = PH_HEADER;
                     end else begin
                        phase_in              = PH_HALTED;
                        push                  = 1'b1;
                        push_entry.kind       = lmbd_pkg::KIND_ERROR;
                        push_entry.error_code = lmbd_pkg::ERR_STREAM_SIG;
                     end
                  end else if (phase_ff == PH_BUF_SIG) begin
                     if (la_word == lmbd_pkg::SIG_BUFFER) begin
                        phase_in = PH_LOOKAHEAD;
                     end else begin
                        phase_in              = PH_HALTED;
                        push                  = 1'b1;
                        push_entry.kind       = lmbd_pkg::KIND_ERROR;
                        push_entry.error_code = lmbd_pkg::ERR_BUFFER_SIG;
                     end
                  end else if (la_word == lmbd_pkg::SIG_END) begin
                     phase_in        = PH_DONE;
                     push            = 1'b1;
                     push_entry.kind = lmbd_pkg::KIND_END;
                  end else begin
                     // Lookahead words are header words zero to three
                     phase_in      = PH_HEADER;
                     blen_in       = la_ff[0];
                     hlen_in       = la_ff[2];
                     hdr_in[47:32] = req_data_word;
                     wc_in         = 5'd4;
                  end
               end
            end
            PH_HEADER: begin
               case (wc_ff)
                  5'd0: blen_in = req_data_word;
                  5'd2: hlen_in = req_data_word;
                  5'd3: hdr_in[47:32] = req_data_word;
                  5'd4: hdr_in[31:16] = req_data_word;
                  5'd5: hdr_in[15:0]  = req_data_word;
                  5'd6: ts_in[15:0]   = req_data_word;
                  5'd7: ts_in[31:16]  = req_data_word;
                  5'd8: ts_in[47:32]  = req_data_word;
                  default: ;
               endcase
               if (wc_ff == LAST_WORD) begin
                  wc_in                 = '0;
                  events_left_in        = quot_ff;
                  phase_in              = (quot_ff != 16'd0) ? PH_EVENTS : PH_BUF_SIG;
                  push                  = 1'b1;
                  push_entry.kind       = lmbd_pkg::KIND_HEADER;
                  push_entry.time_raw   = ts_in;
                  push_entry.hdr_fields = hdr_in;
               end else begin
                  wc_in = wc_ff + 5'd1;
               end
            end
            PH_EVENTS: begin
               if (wc_ff == 5'd0) begin
                  partial_in[15:0] = req_data_word;
                  wc_in            = 5'd1;
               end else if (wc_ff == 5'd1) begin
                  partial_in[31:16] = req_data_word;
                  wc_in             = 5'd2;
               end else begin
                  wc_in                 = '0;
                  events_left_in        = events_left_ff - 16'd1;
                  if (events_left_ff == 16'd1) begin
                     phase_in = PH_BUF_SIG;
                  end
                  push                  = 1'b1;
                  push_entry.kind       = lmbd_pkg::KIND_EVENT;
                  push_entry.event_data = {req_data_word, partial_ff};
                  push_entry.time_raw   = ts_ff;
                  push_entry.hdr_fields = hdr_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_STREAM_SIG;
         wc_ff          <= '0;
         events_left_ff <= '0;
      end else begin
         phase_ff       <= phase_in;
         wc_ff          <= wc_in;
         events_left_ff <= events_left_in;
      end
   end

   // Captured words and the event count pipeline
   always_ff @(posedge clock) begin
      la_ff      <= la_in;
      blen_ff    <= blen_in;
      hlen_ff    <= hlen_in;
      diff_ff    <= diff_in;
      quot_ff    <= quot_in;
      ts_ff      <= ts_in;
      hdr_ff     <= hdr_in;
      partial_ff <= partial_in;
   end

   `LMBD_ASSERT_NEXT(a_halt_holds, clock, reset, phase_ff == PH_HALTED,
      phase_ff == PH_HALTED, "halt left before reset")
   `LMBD_ASSERT_NEXT(a_done_holds, clock, reset, phase_ff == PH_DONE,
      phase_ff == PH_DONE, "end state left before reset")
   `LMBD_ASSERT_IMPLY(a_no_overflow, clock, reset, push, !qstat.full, "push into a full queue")
   `LMBD_ASSERT_IMPLY(a_events_nonzero, clock, reset, phase_ff == PH_EVENTS,
      events_left_ff != 16'd0, "event phase with no events left")

endmodule

// ----- rtl/core/lmbd_fifo.sv -----
// Short queue of result items between the parser and the output stage.
module lmbd_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lmbd_pkg::entry_type  push_entry,
   input  logic                 pop,
   output lmbd_pkg::qstat_type  qstat,
   output lmbd_pkg::entry_type  head
);

   lmbd_pkg::entry_type               slot_ff [lmbd_pkg::QUEUE_DEPTH];
   logic [lmbd_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [lmbd_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [lmbd_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_pop;

   assign qstat.full  = (count_ff == lmbd_pkg::QCNT_W'(lmbd_pkg::QUEUE_DEPTH));
   assign qstat.valid = (count_ff != '0);
   assign head        = slot_ff[rd_ptr_ff];
   assign do_pop      = pop & qstat.valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/core/lmbd_back.sv -----
// Output stage: scales the timestamp and holds the result item.
module lmbd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  lmbd_pkg::qstat_type  qstat,
   input  lmbd_pkg::entry_type  head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_kind,
   output logic [47:0]          rsp_event_data,
   output logic [54:0]          rsp_buffer_time_ns,
   output logic [15:0]          rsp_run_number,
   output logic [15:0]          rsp_buffer_index,
   output logic [7:0]           rsp_source_id,
   output logic [7:0]           rsp_status_bits,
   output logic                 rsp_error_code
);

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff;
   logic [47:0] event_ff;
   logic [54:0] time_ff;
   logic [47:0] hdr_ff;
   logic        code_ff;

   // Load when the output register is empty or being taken
   assign pop      = qstat.valid & (~valid_ff | ~rsp_stall);
   assign valid_in = pop | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff  <= head.kind;
         event_ff <= head.event_data;
         time_ff  <= lmbd_pkg::scale_ns(head.time_raw);
         hdr_ff   <= head.hdr_fields;
         code_ff  <= head.error_code;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_event_data     = event_ff;
   assign rsp_buffer_time_ns = time_ff;
   assign rsp_buffer_index   = hdr_ff[47:32];
   assign rsp_run_number     = hdr_ff[31:16];
   assign rsp_source_id      = hdr_ff[15:8];
   assign rsp_status_bits    = hdr_ff[7:0];
   assign rsp_error_code     = code_ff;

endmodule

// ----- rtl/core/listmode_buffer_deframer.sv -----
// Top level of the list-mode buffer deframer.
// Throughput: one 16-bit word per cycle while the queue has room; req_stall holds words back when it is full.
// A result item reaches rsp by way of a queue slot and then the output register,
// and rsp_stall can hold it in either; req_stall rises only while the queue is full.
// Synchronous reset returns the parser to awaiting the stream signature and empties
// the queue and output register; halt and end of data hold until reset.
module listmode_buffer_deframer #(
   parameter int HEADER_WORDS = 21
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_data_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [47:0] rsp_event_data,
   output logic [54:0] rsp_buffer_time_ns,
   output logic [15:0] rsp_run_number,
   output logic [15:0] rsp_buffer_index,
   output logic [7:0]  rsp_source_id,
   output logic [7:0]  rsp_status_bits,
   output logic        rsp_error_code
);

   lmbd_pkg::qstat_type qstat;
   lmbd_pkg::entry_type push_entry;
   lmbd_pkg::entry_type head;
   logic                push;
   logic                pop;

   lmbd_front #(
      .HEADER_WORDS(HEADER_WORDS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data_word(req_data_word),
      .qstat        (qstat),
      .push         (push),
      .push_entry   (push_entry)
   );

   lmbd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .qstat     (qstat),
      .head      (head)
   );

   lmbd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .qstat             (qstat),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_event_data    (rsp_event_data),
      .rsp_buffer_time_ns(rsp_buffer_time_ns),
      .rsp_run_number    (rsp_run_number),
      .rsp_buffer_index  (rsp_buffer_index),
      .rsp_source_id     (rsp_source_id),
      .rsp_status_bits   (rsp_status_bits),
      .rsp_error_code    (rsp_error_code)
   );

endmodule

// ----- dv/tb_listmode_buffer_deframer.sv -----
// Self-checking testbench for the list-mode buffer deframer: word stream in, result items out.
module tb_listmode_buffer_deframer;

   localparam int HDR_WORDS = 21;

   // One result item as seen on the rsp ports
   typedef struct packed {
      logic [1:0]  kind;
      logic [47:0] event_data;
      logic [54:0] time_ns;
      logic [15:0] run_number;
      logic [15:0] buffer_index;
      logic [7:0]  source_id;
      logic [7:0]  status_bits;
      logic        error_code;
   } result_type;

   // How a stimulus row is checked
   typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_TYPED} row_check_type;

   typedef struct packed {
      logic [15:0]   word;
      row_check_type check;
      result_type    typed;
   } stim_row_type;

   typedef enum logic [2:0] {
      PH_STREAM_SIG, PH_HEADER, PH_EVENTS, PH_BUF_SIG, PH_LOOKAHEAD, PH_DONE, PH_HALTED
   } parse_phase_type;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   localparam result_type NO_RESULT = '0;
   // All-ones timestamp, all-ones buffer number, zero run id
   localparam result_type HDR_EXTREME = '{
      kind: lmbd_pkg::KIND_HEADER, event_data: 48'd0, time_ns: 55'd28147497671065500,
      run_number: 16'h0000, buffer_index: 16'hFFFF, source_id: 8'hA5,
      status_bits: 8'h5A, error_code: 1'b0};

   // Stream signature, one header with a short length, buffer signature
   localparam stim_row_type OPENING_ROWS [29] = '{
      '{lmbd_pkg::SIG_STREAM[63:48], ROW_QUIET, NO_RESULT},
      '{lmbd_pkg::SIG_STREAM[47:32], ROW_QUIET, NO_RESULT},
      '{lmbd_pkg::SIG_STREAM[31:16], ROW_QUIET, NO_RESULT},
      '{lmbd_pkg::SIG_STREAM[15:0],  ROW_QUIET, NO_RESULT},
      '{16'h0002, ROW_QUIET, NO_RESULT},   // length below header length: no events
      '{16'hFFFF, ROW_QUIET, NO_RESULT},
      '{16'h0015, ROW_QUIET, NO_RESULT},   // header length
      '{16'hFFFF, ROW_QUIET, NO_RESULT},   // buffer number
      '{16'h0000, ROW_QUIET, NO_RESULT},   // run id
      '{16'hA55A, ROW_QUIET, NO_RESULT},   // source and status
      '{16'hFFFF, ROW_QUIET, NO_RESULT},   // timestamp low, mid, high
      '{16'hFFFF, ROW_QUIET, NO_RESULT},
      '{16'hFFFF, ROW_QUIET, NO_RESULT},
      '{16'h0000, ROW_QUIET, NO_RESULT},
      '{16'hFFFF, ROW_QUIET, NO_RESULT},
      '{16'h0000, ROW_QUIET, NO_RESULT},
      '{16'hFFFF, ROW_QUIET, NO_RESULT},
      '{16'h0000, ROW_QUIET, NO_RESULT},
      '{16'hFFFF, ROW_QUIET, NO_RESULT},
      '{16'h0000, ROW_QUIET, NO_RESULT},
      '{16'hFFFF, ROW_QUIET, NO_RESULT},
      '{16'h0000, ROW_QUIET, NO_RESULT},
      '{16'hFFFF, ROW_QUIET, NO_RESULT},
      '{16'h0000, ROW_QUIET, NO_RESULT},
      '{16'h0000, ROW_TYPED, HDR_EXTREME},
      '{lmbd_pkg::SIG_BUFFER[63:48], ROW_QUIET, NO_RESULT},
      '{lmbd_pkg::SIG_BUFFER[47:32], ROW_QUIET, NO_RESULT},
      '{lmbd_pkg::SIG_BUFFER[31:16], ROW_QUIET, NO_RESULT},
      '{lmbd_pkg::SIG_BUFFER[15:0],  ROW_QUIET, NO_RESULT}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_data_word = 16'h0000;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [47:0] rsp_event_data;
   logic [54:0] rsp_buffer_time_ns;
   logic [15:0] rsp_run_number;
   logic [15:0] rsp_buffer_index;
   logic [7:0]  rsp_source_id;
   logic [7:0]  rsp_status_bits;
   logic        rsp_error_code;

   stim_row_type stim_q [$];
   result_type   results_due [$];
   int           send_idx = 0;
   int           accept_count = 0;
   int           fail_count = 0;

   // Deframer state as the predictor tracks it
   parse_phase_type dp_phase = PH_STREAM_SIG;
   logic [4:0]      dp_word_idx = '0;
   logic [15:0]     dp_events_left = '0;
   logic [15:0]     dp_look [4] = '{default: '0};
   logic [15:0]     dp_length = '0;
   logic [15:0]     dp_hdr_length = '0;
   logic [31:0]     dp_time_lo = '0;
   logic [54:0]     dp_time_ns = '0;
   logic [31:0]     dp_event_lo = '0;
   logic [47:0]     dp_hdr_fields = '0;

   always #5 clock = ~clock;

   listmode_buffer_deframer #(.HEADER_WORDS(HDR_WORDS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_word      (req_data_word),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_event_data     (rsp_event_data),
      .rsp_buffer_time_ns (rsp_buffer_time_ns),
      .rsp_run_number     (rsp_run_number),
      .rsp_buffer_index   (rsp_buffer_index),
      .rsp_source_id      (rsp_source_id),
      .rsp_status_bits    (rsp_status_bits),
      .rsp_error_code     (rsp_error_code)
   );

   // Attach the current buffer header fields to a result item
   function automatic result_type with_header_info(input result_type r);
      r.time_ns      = dp_time_ns;
      r.buffer_index = dp_hdr_fields[47:32];
      r.run_number   = dp_hdr_fields[31:16];
      r.source_id    = dp_hdr_fields[15:8];
      r.status_bits  = dp_hdr_fields[7:0];
      return r;
   endfunction

   // Take one header word; flag the header item once the last word is in
   task absorb_header_word(input logic [15:0] w, output bit done, output result_type r);
      logic [63:0] scaled;
      done = 1'b0;
      r = '0;
      case (dp_word_idx)
         5'd0: dp_length = w;
         5'd2: dp_hdr_length = w;
         5'd3: dp_hdr_fields[47:32] = w;
         5'd4: dp_hdr_fields[31:16] = w;
         5'd5: dp_hdr_fields[15:0] = w;
         5'd6: dp_time_lo = {16'h0000, w};
         5'd7: dp_time_lo[31:16] = w;
         5'd8: begin
            scaled = {16'h0000, w, dp_time_lo} * 64'd100;
            dp_time_ns = scaled[54:0];
         end
         default: ;
      endcase
      if (int'(dp_word_idx) + 1 >= HDR_WORDS) begin
         dp_word_idx = '0;
         dp_events_left = (dp_length >= dp_hdr_length) ?
                          16'((dp_length - dp_hdr_length) / 3) : 16'd0;
         dp_phase = (dp_events_left != 16'd0) ? PH_EVENTS : PH_BUF_SIG;
         done = 1'b1;
         r.kind = lmbd_pkg::KIND_HEADER;
         r = with_header_info(r);
      end else begin
         dp_word_idx = dp_word_idx + 5'd1;
      end
   endtask

   // Advance the predicted deframer by one stream word
   task deframe_word(input logic [15:0] w, output bit produced, output result_type r);
      logic [63:0] sig;
      bit          done;
      result_type  hdr_r;
      produced = 1'b0;
      r = '0;
      case (dp_phase)
         PH_STREAM_SIG, PH_BUF_SIG, PH_LOOKAHEAD: begin
            dp_look[dp_word_idx[1:0]] = w;
            if (dp_word_idx[1:0] != 2'd3) begin
               dp_word_idx = {3'd0, dp_word_idx[1:0] + 2'd1};
            end else begin
               dp_word_idx = '0;
               sig = {dp_look[0], dp_look[1], dp_look[2], dp_look[3]};
               if (dp_phase == PH_STREAM_SIG) begin
                  if (sig == lmbd_pkg::SIG_STREAM) begin
                     dp_phase = PH_HEADER;
                  end else begin
                     dp_phase = PH_HALTED;
                     produced = 1'b1;
                     r.kind = lmbd_pkg::KIND_ERROR;
                     r.error_code = lmbd_pkg::ERR_STREAM_SIG;
                  end
               end else if (dp_phase == PH_BUF_SIG) begin
                  if (sig == lmbd_pkg::SIG_BUFFER) begin
                     dp_phase = PH_LOOKAHEAD;
                  end else begin
                     dp_phase = PH_HALTED;
                     produced = 1'b1;
                     r.kind = lmbd_pkg::KIND_ERROR;
                     r.error_code = lmbd_pkg::ERR_BUFFER_SIG;
                  end
               end else if (sig == lmbd_pkg::SIG_END) begin
                  dp_phase = PH_DONE;
                  produced = 1'b1;
                  r.kind = lmbd_pkg::KIND_END;
               end else begin
                  // replay the lookahead words as the start of the next header
                  dp_phase = PH_HEADER;
                  for (int i = 0; i < 4; i++) begin
                     absorb_header_word(dp_look[i], done, hdr_r);
                     if (done) begin
                        produced = 1'b1;
                        r = hdr_r;
                        break;
                     end
                  end
               end
            end
         end
         PH_HEADER: absorb_header_word(w, produced, r);
         PH_EVENTS: begin
            if (dp_word_idx == 5'd0) begin
               dp_event_lo = {16'h0000, w};
               dp_word_idx = 5'd1;
            end else if (dp_word_idx == 5'd1) begin
               dp_event_lo[31:16] = w;
               dp_word_idx = 5'd2;
            end else begin
               dp_word_idx = '0;
               produced = 1'b1;
               r.kind = lmbd_pkg::KIND_EVENT;
               r.event_data = {w, dp_event_lo};
               r = with_header_info(r);
               dp_events_left = dp_events_left - 16'd1;
               if (dp_events_left == 16'd0) dp_phase = PH_BUF_SIG;
            end
         end
         default: ;
      endcase
   endtask

   function automatic string describe(input result_type r);
      return $sformatf("kind %0d event %h time %0d run %h buf %h src %h status %h err %b",
                       r.kind, r.event_data, r.time_ns, r.run_number, r.buffer_index,
                       r.source_id, r.status_bits, r.error_code);
   endfunction

   task report_failure(input string what, input result_type exp, input result_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s", $realtime, what);
         $display("   expected %s", describe(exp));
         $display("   actual   %s", describe(got));
      end
   endtask

   task automatic add_word(input logic [15:0] w);
      stim_q.push_back('{word: w, check: ROW_PREDICT, typed: NO_RESULT});
   endtask

   // Queue one buffer: header, events, buffer signature (optionally corrupted)
   task automatic add_buffer(input bit broken_sig);
      logic [15:0] hdr [HDR_WORDS];
      logic [15:0] sig_words [4];
      int          pick, n_ev, need, len_i, hl_i;
      pick = $urandom_range(19);
      for (int i = 0; i < HDR_WORDS; i++) hdr[i] = 16'($urandom);
      if (pick < 14) begin
         // well-formed length, header length anywhere in range
         n_ev = (pick == 0) ? $urandom_range(40, 20) : $urandom_range(8, 0);
         need = 3 * n_ev + $urandom_range(2, 0);
         hl_i = $urandom_range(65535 - need, 0);
         len_i = hl_i + need;
      end else if (pick < 17) begin
         // length below header length
         len_i = $urandom_range(65534, 0);
         hl_i = $urandom_range(65535, len_i + 1);
      end else if (pick < 19) begin
         // first four words miss the end signature in the first word only
         hdr[1] = lmbd_pkg::SIG_END[47:32];
         hdr[3] = lmbd_pkg::SIG_END[15:0];
         hl_i = int'(lmbd_pkg::SIG_END[31:16]);
         len_i = $urandom_range(hl_i + 30, hl_i - 40);
      end else begin
         // first four words miss the end signature in the third word only
         hdr[1] = lmbd_pkg::SIG_END[47:32];
         hdr[3] = lmbd_pkg::SIG_END[15:0];
         len_i = int'(lmbd_pkg::SIG_END[63:48]);
         hl_i = $urandom_range(16'hFFFE, 16'hFFE0);
      end
      hdr[0] = 16'(len_i);
      hdr[2] = 16'(hl_i);
      n_ev = (len_i >= hl_i) ? (len_i - hl_i) / 3 : 0;
      for (int i = 0; i < HDR_WORDS; i++) add_word(hdr[i]);
      for (int i = 0; i < 3 * n_ev; i++) add_word(16'($urandom));
      for (int k = 0; k < 4; k++) sig_words[k] = lmbd_pkg::SIG_BUFFER[63 - 16 * k -: 16];
      if (broken_sig) begin
         need = $urandom_range(3);
         pick = $urandom_range(15);
         sig_words[need][pick] = ~sig_words[need][pick];
      end
      for (int k = 0; k < 4; k++) add_word(sig_words[k]);
   endtask

   // Predict accepted words, check result items, drive both channels
   always @(posedge clock) begin
      result_type    predicted;
      result_type    got;
      bit            produced;
      idle_mode_type mode;
      int            sender_pct;
      int            receiver_pct;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         // predict each accepted item
         if (req_valid && !req_stall) begin
            deframe_word(req_data_word, produced, predicted);
            case (stim_q[accept_count].check)
               ROW_PREDICT: if (produced) results_due.push_back(predicted);
               ROW_TYPED:   results_due.push_back(stim_q[accept_count].typed);
               default: ;
            endcase
            accept_count++;
         end

         // compare each accepted result item with the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            got = '{kind: rsp_kind, event_data: rsp_event_data, time_ns: rsp_buffer_time_ns,
                    run_number: rsp_run_number, buffer_index: rsp_buffer_index,
                    source_id: rsp_source_id, status_bits: rsp_status_bits,
                    error_code: rsp_error_code};
            if (results_due.size() == 0) begin
               report_failure("result with nothing expected", NO_RESULT, got);
            end else begin
               predicted = results_due.pop_front();
               if (got !== predicted) report_failure("result mismatch", predicted, got);
            end
         end

         // pick the idling mix for this stretch of the run
         mode = idle_mode_type'((send_idx * 4) / stim_q.size() > 3 ?
                                3 : (send_idx * 4) / stim_q.size());
         case (mode)
            IDLE_SENDER:   begin sender_pct = 61; receiver_pct = 0;  end
            IDLE_RECEIVER: begin sender_pct = 0;  receiver_pct = 61; end
            IDLE_BOTH:     begin sender_pct = 10; receiver_pct = 10; end
            default:       begin sender_pct = 0;  receiver_pct = 0;  end
         endcase

         // advance to the next item unless the current one is stalled
         if (!req_valid || !req_stall) begin
            if (send_idx < stim_q.size() && $urandom_range(99) >= sender_pct) begin
               req_valid <= 1'b1;
               req_data_word <= stim_q[send_idx].word;
               send_idx++;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_pct);
      end
   end

   initial begin
      int wait_cycles;
      foreach (OPENING_ROWS[i]) stim_q.push_back(OPENING_ROWS[i]);
      while (stim_q.size() < 1430) add_buffer(1'b0);
      // close the stream either cleanly or with a corrupted buffer signature
      if ($urandom_range(1) == 0) begin
         for (int k = 0; k < 4; k++) add_word(lmbd_pkg::SIG_END[63 - 16 * k -: 16]);
      end else begin
         add_buffer(1'b1);
      end
      // words after the stream stops are ignored
      for (int i = 0; i < 12; i++) add_word(16'($urandom));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (accept_count < stim_q.size()) @(posedge clock);
      wait_cycles = 0;
      while (results_due.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (10) @(posedge clock);

      if (results_due.size() != 0) begin
         fail_count += results_due.size();
         $display("%0d expected result items never arrived", results_due.size());
      end
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Hard stop in case the block hangs
   initial begin
      #3000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
